// ===== rtl/core/llsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types for the latitude/longitude to Cartesian pipeline.
// No dependencies; every other file in rtl/core refers to it by scoped name.
package llsc_pkg;

  // Field widths
  localparam int DEG_W    = 33;
  localparam int TURN_W   = 32;
  localparam int UNIT_W   = 32;
  localparam int POS_W    = 32;
  localparam int RADIUS_W = 23;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int ROTATION_STEPS  = 24;

  // Degrees to binary angle: (|deg| << TURN_SHIFT + 180) / 360 is worked as
  // (|deg| << (TURN_SHIFT - 3) + 22) / 45, the divide by 45 a byte at a time.
  localparam int TURN_SHIFT = TURN_W - ANGLE_FRAC_BITS;
  localparam int NUM_SHIFT  = TURN_SHIFT - 3;
  localparam int NUM_W      = DEG_W + NUM_SHIFT;
  localparam int DIGIT_W    = 8;
  localparam int DIV_STAGES = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W      = DIV_STAGES * DIGIT_W;
  localparam int REM_W      = 6;
  localparam int PART_W     = REM_W + DIGIT_W;
  localparam int RECIP_W    = 15;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W     = PART_W + RECIP_W;
  localparam logic [REM_W-1:0]   DIV_DEN    = 6'd45;
  localparam logic [RECIP_W-1:0] DIV_RECIP  = 15'd23302;
  localparam logic [DIGIT_W-1:0] ROUND_BIAS = 8'd22;

  // CORDIC datapath
  localparam int CX_W = 33;
  localparam int CZ_W = 34;
  localparam logic signed [CX_W-1:0] INV_GAIN = 33'sd652032874;
  localparam logic signed [CX_W-1:0] UNIT_POS = 33'sd1073741824;
  localparam logic signed [CX_W-1:0] UNIT_NEG = -33'sd1073741824;
  localparam logic [TURN_W-1:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [TURN_W-1:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Q2.30 products
  localparam int MUL_W    = 64;
  localparam int MUL_FRAC = 30;
  localparam logic signed [MUL_W-1:0] MUL_ROUND = 64'sd536870912;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [REM_W-1:0]   rem;
  } div_res_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] clat;
    logic signed [UNIT_W-1:0] slat;
    logic signed [UNIT_W-1:0] clon;
    logic signed [UNIT_W-1:0] slon;
  } trig_t;

  // One quotient byte of a divide by 45: reciprocal multiply, exact for part < 45 * 256
  function automatic div_res_t div_digit(input logic [PART_W-1:0] part);
    logic [PROD_W-1:0] prod;
    logic [PART_W-1:0] back;
    div_res_t          res;
    prod      = PROD_W'(part) * PROD_W'(DIV_RECIP);
    res.digit = prod[RECIP_SHIFT +: DIGIT_W];
    back      = PART_W'(res.digit) * PART_W'(DIV_DEN);
    res.rem   = REM_W'(part - back);
    return res;
  endfunction

  // Q2.30 product, rounded half up
  function automatic logic signed [UNIT_W-1:0] mul_round(input logic signed [UNIT_W-1:0] a,
                                                         input logic signed [UNIT_W-1:0] b);
    logic signed [MUL_W-1:0] prod;
    logic signed [MUL_W-1:0] sum;
    prod = MUL_W'(a) * MUL_W'(b);
    sum  = (prod + MUL_ROUND) >>> MUL_FRAC;
    return sum[UNIT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/llsc_turn.sv =====
`timescale 1ns / 1ps
// Degrees to binary angle for both lanes: magnitude prep, then a byte-per-stage divide by 45.
// Depends on llsc_pkg.
module llsc_turn (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [llsc_pkg::DEG_W-1:0]       lat_i,
  input  logic signed [llsc_pkg::DEG_W-1:0]       lon_i,
  output logic                                    valid_o,
  output logic [1:0][llsc_pkg::TURN_W-1:0]        turn_o
);

  logic [llsc_pkg::DIV_STAGES:0] valid_q;

  logic                          neg_q [llsc_pkg::DIV_STAGES+1][2];
  logic [llsc_pkg::DIV_W-1:0]    num_q [llsc_pkg::DIV_STAGES+1][2];
  logic [llsc_pkg::REM_W-1:0]    rem_q [llsc_pkg::DIV_STAGES+1][2];
  logic [llsc_pkg::TURN_W-1:0]   quo_q [llsc_pkg::DIV_STAGES+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[llsc_pkg::DIV_STAGES-1:0], valid_i};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [llsc_pkg::DEG_W-1:0] deg;
    logic [llsc_pkg::DEG_W-1:0]        mag;

    assign deg = (l == 0) ? lat_i : lon_i;
    assign mag = deg[llsc_pkg::DEG_W-1] ? llsc_pkg::DEG_W'(-deg) : llsc_pkg::DEG_W'(deg);

    // Magnitude, prescaled, with the half-unit bias for rounding away from zero
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[0][l] <= deg[llsc_pkg::DEG_W-1];
        num_q[0][l] <= (llsc_pkg::DIV_W'(mag) << llsc_pkg::NUM_SHIFT)
                       + llsc_pkg::DIV_W'(llsc_pkg::ROUND_BIAS);
        rem_q[0][l] <= '0;
        quo_q[0][l] <= '0;
      end
    end

    for (genvar k = 0; k < llsc_pkg::DIV_STAGES; k++) begin : g_div
      logic [llsc_pkg::PART_W-1:0] part;
      llsc_pkg::div_res_t          res;

      assign part = {rem_q[k][l],
                     num_q[k][l][llsc_pkg::DIV_W-1-k*llsc_pkg::DIGIT_W -: llsc_pkg::DIGIT_W]};
      assign res  = llsc_pkg::div_digit(part);

      // Quotient bits beyond one turn drop off the top
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          neg_q[k+1][l] <= neg_q[k][l];
          num_q[k+1][l] <= num_q[k][l];
          rem_q[k+1][l] <= res.rem;
          quo_q[k+1][l] <= {quo_q[k][l][llsc_pkg::TURN_W-llsc_pkg::DIGIT_W-1:0], res.digit};
        end
      end
    end

    assign turn_o[l] = neg_q[llsc_pkg::DIV_STAGES][l] ? -quo_q[llsc_pkg::DIV_STAGES][l]
                                                      : quo_q[llsc_pkg::DIV_STAGES][l];
  end

  assign valid_o = valid_q[llsc_pkg::DIV_STAGES];

endmodule

// ===== rtl/core/llsc_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation CORDIC for both lanes: quadrant fold, one step per stage, flip and clamp.
// Depends on llsc_pkg.
module llsc_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [1:0][llsc_pkg::TURN_W-1:0]   turn_i,
  output logic                               valid_o,
  output llsc_pkg::trig_t                    trig_o
);

  logic [llsc_pkg::ROTATION_STEPS+1:0] valid_q;

  logic signed [llsc_pkg::CX_W-1:0] x_q    [llsc_pkg::ROTATION_STEPS+1][2];
  logic signed [llsc_pkg::CX_W-1:0] y_q    [llsc_pkg::ROTATION_STEPS+1][2];
  logic signed [llsc_pkg::CZ_W-1:0] z_q    [llsc_pkg::ROTATION_STEPS+1][2];
  logic                             flip_q [llsc_pkg::ROTATION_STEPS+1][2];
  llsc_pkg::trig_t                  trig_q;

  function automatic logic signed [llsc_pkg::UNIT_W-1:0] finish(
    input logic signed [llsc_pkg::CX_W-1:0] v,
    input logic                             flip
  );
    logic signed [llsc_pkg::CX_W-1:0] f;
    f = flip ? -v : v;
    if (f > llsc_pkg::UNIT_POS) begin
      f = llsc_pkg::UNIT_POS;
    end else if (f < llsc_pkg::UNIT_NEG) begin
      f = llsc_pkg::UNIT_NEG;
    end
    return f[llsc_pkg::UNIT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[llsc_pkg::ROTATION_STEPS:0], valid_i};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic                          fold;
    logic [llsc_pkg::TURN_W-1:0]   t;

    // Fold the two far quadrants by half a turn; negate both outputs at the end
    assign fold = (turn_i[l] > llsc_pkg::QUARTER_TURN) &&
                  (turn_i[l] < llsc_pkg::THREE_QUARTER_TURN);
    assign t    = fold ? (turn_i[l] ^ llsc_pkg::HALF_TURN) : turn_i[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0][l]    <= llsc_pkg::INV_GAIN;
        y_q[0][l]    <= '0;
        z_q[0][l]    <= llsc_pkg::CZ_W'($signed(t));
        flip_q[0][l] <= fold;
      end
    end

    for (genvar i = 0; i < llsc_pkg::ROTATION_STEPS; i++) begin : g_step
      logic signed [llsc_pkg::CX_W-1:0] dx;
      logic signed [llsc_pkg::CX_W-1:0] dy;
      logic signed [llsc_pkg::CZ_W-1:0] atan;

      assign dx   = y_q[i][l] >>> i;
      assign dy   = x_q[i][l] >>> i;
      assign atan = llsc_pkg::CZ_W'(llsc_pkg::ATAN_TABLE[i]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          flip_q[i+1][l] <= flip_q[i][l];
          if (!z_q[i][l][llsc_pkg::CZ_W-1]) begin
            x_q[i+1][l] <= x_q[i][l] - dx;
            y_q[i+1][l] <= y_q[i][l] + dy;
            z_q[i+1][l] <= z_q[i][l] - atan;
          end else begin
            x_q[i+1][l] <= x_q[i][l] + dx;
            y_q[i+1][l] <= y_q[i][l] - dy;
            z_q[i+1][l] <= z_q[i][l] + atan;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.clat <= finish(x_q[llsc_pkg::ROTATION_STEPS][0], flip_q[llsc_pkg::ROTATION_STEPS][0]);
      trig_q.slat <= finish(y_q[llsc_pkg::ROTATION_STEPS][0], flip_q[llsc_pkg::ROTATION_STEPS][0]);
      trig_q.clon <= finish(x_q[llsc_pkg::ROTATION_STEPS][1], flip_q[llsc_pkg::ROTATION_STEPS][1]);
      trig_q.slon <= finish(y_q[llsc_pkg::ROTATION_STEPS][1], flip_q[llsc_pkg::ROTATION_STEPS][1]);
    end
  end

  assign valid_o = valid_q[llsc_pkg::ROTATION_STEPS+1];
  assign trig_o  = trig_q;

endmodule

// ===== rtl/core/llsc_scale.sv =====
`timescale 1ns / 1ps
// Products of the trig terms, radius scaling and the output register with its skid word.
// Depends on llsc_pkg.
module llsc_scale (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  llsc_pkg::trig_t                       trig_i,
  input  logic [llsc_pkg::RADIUS_W-1:0]         radius_i,
  output logic                                  en_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [llsc_pkg::POS_W-1:0]     pos_x_o,
  output logic signed [llsc_pkg::POS_W-1:0]     pos_y_o,
  output logic signed [llsc_pkg::POS_W-1:0]     pos_z_o
);

  typedef struct packed {
    logic signed [llsc_pkg::POS_W-1:0] x;
    logic signed [llsc_pkg::POS_W-1:0] y;
    logic signed [llsc_pkg::POS_W-1:0] z;
  } pos_t;

  logic                               en;
  logic                               prod_v_q;
  logic signed [llsc_pkg::UNIT_W-1:0] cc_q;
  logic signed [llsc_pkg::UNIT_W-1:0] cs_q;
  logic signed [llsc_pkg::UNIT_W-1:0] sl_q;
  logic signed [llsc_pkg::UNIT_W-1:0] r8;
  pos_t                               pos_new;
  pos_t                               out_q;
  pos_t                               skid_q;
  logic                               out_v_q;
  logic                               skid_v_q;
  logic                               push;
  logic                               take;

  // The pipe advances unless a word is parked in the skid register
  assign en   = !skid_v_q;
  assign push = en && prod_v_q;
  assign take = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (en) begin
      prod_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q <= llsc_pkg::mul_round(trig_i.clat, trig_i.clon);
      cs_q <= llsc_pkg::mul_round(trig_i.clat, trig_i.slon);
      sl_q <= trig_i.slat;
    end
  end

  assign r8        = $signed({1'b0, radius_i, 8'd0});
  assign pos_new.x = llsc_pkg::mul_round(r8, cc_q);
  assign pos_new.y = llsc_pkg::mul_round(r8, cs_q);
  assign pos_new.z = llsc_pkg::mul_round(r8, sl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= pos_new;
      end else begin
        out_q <= pos_new;
      end
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_v_q;
  assign pos_x_o     = out_q.x;
  assign pos_y_o     = out_q.y;
  assign pos_z_o     = out_q.z;

endmodule

// ===== rtl/core/latlon_to_sphere_cartesian.sv =====
`timescale 1ns / 1ps
// Top level: latitude/longitude to Cartesian position on a sphere, radius register included.
// Depends on llsc_pkg, llsc_turn, llsc_cordic and llsc_scale.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries lat_deg_i and lon_deg_i, signed degrees
//   with 24 fraction bits. Output channel out_valid_o/out_ready_i carries pos_x_o,
//   pos_y_o and pos_z_o, signed metres with 8 fraction bits. A word moves on a
//   channel at a rising edge with valid and ready both high.
//   cfg_we_i writes cfg_wdata_i into the radius register (whole metres) at once;
//   write it only while no word is in flight.
//   From input accept to out_valid_o a word passes one prep stage, five
//   divide stages (one quotient byte each), fold, 24 CORDIC steps, clamp, the
//   trig product stage and the output register. While the pipe is not held,
//   throughput is one word per cycle, set by the fully pipelined CORDIC and divider.
//   Reset clears every valid bit and loads the radius with 6371000 m.
//   When the receiver stalls, one result waits in the output register and the
//   next is caught in a skid register; only then does the whole pipe hold and
//   in_ready_o fall, so nothing is dropped or repeated.
module latlon_to_sphere_cartesian (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [llsc_pkg::DEG_W-1:0]   lat_deg_i,
  input  logic signed [llsc_pkg::DEG_W-1:0]   lon_deg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [llsc_pkg::POS_W-1:0]   pos_x_o,
  output logic signed [llsc_pkg::POS_W-1:0]   pos_y_o,
  output logic signed [llsc_pkg::POS_W-1:0]   pos_z_o,
  input  logic                                cfg_we_i,
  input  logic [llsc_pkg::RADIUS_W-1:0]       cfg_wdata_i
);

  logic [llsc_pkg::RADIUS_W-1:0]       radius_q;
  logic                                en;
  logic                                turn_v;
  logic [1:0][llsc_pkg::TURN_W-1:0]    turn;
  logic                                trig_v;
  llsc_pkg::trig_t                     trig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= llsc_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = en;

  llsc_turn u_turn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .lat_i   (lat_deg_i),
    .lon_i   (lon_deg_i),
    .valid_o (turn_v),
    .turn_o  (turn)
  );

  llsc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (turn_v),
    .turn_i  (turn),
    .valid_o (trig_v),
    .trig_o  (trig)
  );

  llsc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (trig_v),
    .trig_i      (trig),
    .radius_i    (radius_q),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o)
  );

endmodule
